@@ rtl/core/packstream_value_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// packstream_value_encoder_macros.svh
// Assertion helpers used by the encoder RTL (pvenc_serial).
// ----------------------------------------------------------------------------
`ifndef PACKSTREAM_VALUE_ENCODER_MACROS_SVH
`define PACKSTREAM_VALUE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVENC_ASSERT_IMP(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
    else $error("pvenc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVENC_ASSERT_NXT(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
    else $error("pvenc assertion failed");

`endif

@@ rtl/core/pvenc_pkg.sv @@
// ----------------------------------------------------------------------------
// pvenc_pkg
// Request kinds, marker bytes and stage records of the value encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pvenc_pkg;

  // Request kinds
  localparam logic [3:0] MODE_NULL   = 4'd0;
  localparam logic [3:0] MODE_BOOL   = 4'd1;
  localparam logic [3:0] MODE_INT    = 4'd2;
  localparam logic [3:0] MODE_FLOAT  = 4'd3;
  localparam logic [3:0] MODE_STRING = 4'd4;
  localparam logic [3:0] MODE_LIST   = 4'd5;
  localparam logic [3:0] MODE_MAP    = 4'd6;
  localparam logic [3:0] MODE_STRUCT = 4'd7;
  localparam logic [3:0] MODE_RAW    = 4'd8;

  // Marker bytes
  localparam logic [7:0] MK_NULL       = 8'hC0;
  localparam logic [7:0] MK_FLOAT      = 8'hC1;
  localparam logic [7:0] MK_FALSE      = 8'hC2;
  localparam logic [7:0] MK_TRUE       = 8'hC3;
  localparam logic [7:0] MK_INT8       = 8'hC8;
  localparam logic [7:0] MK_INT16      = 8'hC9;
  localparam logic [7:0] MK_INT32      = 8'hCA;
  localparam logic [7:0] MK_INT64      = 8'hCB;
  localparam logic [7:0] MK_TINY_STR   = 8'h80;
  localparam logic [7:0] MK_TINY_LIST  = 8'h90;
  localparam logic [7:0] MK_TINY_MAP   = 8'hA0;
  localparam logic [7:0] MK_TINY_STRCT = 8'hB0;
  localparam logic [7:0] MK_STRCT_SAT  = 8'hBF;
  localparam logic [7:0] MK_STR8       = 8'hD0;
  localparam logic [7:0] MK_STR16      = 8'hD1;
  localparam logic [7:0] MK_STR32      = 8'hD2;
  localparam logic [7:0] MK_LIST8      = 8'hD4;
  localparam logic [7:0] MK_LIST16     = 8'hD5;
  localparam logic [7:0] MK_LIST32     = 8'hD6;
  localparam logic [7:0] MK_MAP8       = 8'hD8;
  localparam logic [7:0] MK_MAP16      = 8'hD9;
  localparam logic [7:0] MK_MAP32      = 8'hDA;

  // Longest encoding: marker plus eight payload bytes
  localparam int unsigned MAX_BYTES = 9;

  // Classified request: marker, payload and payload byte count
  typedef struct packed {
    logic [7:0]  marker;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        err;
  } cls_t;

  // Assembled frame, byte 0 goes out first
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      err;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/core/pvenc_in_if.sv @@
// ----------------------------------------------------------------------------
// pvenc_in_if
// Request channel: one typed value per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvenc_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [63:0] value;
  logic [31:0]        size;
  logic [7:0]         struct_tag;

  modport source (output valid, output mode, output value, output size,
                  output struct_tag, input ready);
  modport sink   (input valid, input mode, input value, input size,
                  input struct_tag, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pvenc_out_if.sv @@
// ----------------------------------------------------------------------------
// pvenc_out_if
// Byte channel: one encoded byte per handshake with last and error marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input error,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/packstream_value_encoder.sv @@
// Path: a taken request passes three register stages (classify, frame, serial buffer)
// before its first byte is offered on the output channel.
// Throughput: one request per cycle enters the pipeline while it is not stalled; the byte
// serialiser sends one byte per cycle while the sink is ready: marker plus 0..8 payload bytes.
// Unknown kinds are dropped in the first stage and go no further down the pipeline.
// Reset: synchronous active-low rst_n clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// packstream_value_encoder
// Typed value to PackStream byte stream encoder, three-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module packstream_value_encoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pvenc_in_if.sink    in_req,
  pvenc_out_if.source out_res
);
  import pvenc_pkg::*;

  logic   cls_valid;
  cls_t   cls_data;
  logic   cls_ready;
  logic   frm_valid;
  frame_t frm_data;
  logic   frm_ready;

  // Decode kind and range
  pvenc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cls_valid (cls_valid),
    .cls_data  (cls_data),
    .cls_ready (cls_ready)
  );

  // Lay out bytes
  pvenc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls_data  (cls_data),
    .cls_ready (cls_ready),
    .frm_valid (frm_valid),
    .frm_data  (frm_data),
    .frm_ready (frm_ready)
  );

  // Send bytes
  pvenc_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm_data  (frm_data),
    .frm_ready (frm_ready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

@@ rtl/core/pvenc_classify.sv @@
// ----------------------------------------------------------------------------
// pvenc_classify
// Stage one: pick the marker, payload and payload length of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module pvenc_classify (
  input  wire logic         clk,
  input  wire logic         rst_n,
  pvenc_in_if.sink          in_req,
  output logic              cls_valid,
  output pvenc_pkg::cls_t   cls_data,
  input  wire logic         cls_ready
);
  import pvenc_pkg::*;

  logic valid_r;
  cls_t cls_r;
  cls_t cls_nxt;
  logic keep;
  logic advance;
  logic int_tiny;
  logic int_8;
  logic int_16;
  logic int_32;
  logic [7:0] mk_tiny;
  logic [7:0] mk_8;
  logic [7:0] mk_16;
  logic [7:0] mk_32;

  // Signed range tests: upper bits all equal to the sign
  always_comb begin
    int_tiny = (in_req.value[63:7] == '0) || (&in_req.value[63:4]);
    int_8    = (in_req.value[63:7] == '0) || (&in_req.value[63:7]);
    int_16   = (in_req.value[63:15] == '0) || (&in_req.value[63:15]);
    int_32   = (in_req.value[63:31] == '0) || (&in_req.value[63:31]);
  end

  // Size header marker set per collection kind
  always_comb begin
    case (in_req.mode)
      MODE_LIST: begin
        mk_tiny = MK_TINY_LIST; mk_8 = MK_LIST8; mk_16 = MK_LIST16; mk_32 = MK_LIST32;
      end
      MODE_MAP: begin
        mk_tiny = MK_TINY_MAP; mk_8 = MK_MAP8; mk_16 = MK_MAP16; mk_32 = MK_MAP32;
      end
      default: begin
        mk_tiny = MK_TINY_STR; mk_8 = MK_STR8; mk_16 = MK_STR16; mk_32 = MK_STR32;
      end
    endcase
  end

  // Decode the request kind
  always_comb begin
    cls_nxt.marker = MK_NULL;
    cls_nxt.data   = in_req.value;
    cls_nxt.nbytes = 4'd0;
    cls_nxt.err    = 1'b0;
    keep           = 1'b1;
    case (in_req.mode)
      MODE_NULL: cls_nxt.marker = MK_NULL;
      MODE_BOOL: cls_nxt.marker = in_req.value[0] ? MK_TRUE : MK_FALSE;
      MODE_INT: begin
        if (int_tiny) begin
          cls_nxt.marker = in_req.value[7:0];
        end else if (int_8) begin
          cls_nxt.marker = MK_INT8;  cls_nxt.nbytes = 4'd1;
        end else if (int_16) begin
          cls_nxt.marker = MK_INT16; cls_nxt.nbytes = 4'd2;
        end else if (int_32) begin
          cls_nxt.marker = MK_INT32; cls_nxt.nbytes = 4'd4;
        end else begin
          cls_nxt.marker = MK_INT64; cls_nxt.nbytes = 4'd8;
        end
      end
      MODE_FLOAT: begin
        cls_nxt.marker = MK_FLOAT;
        cls_nxt.nbytes = 4'd8;
      end
      MODE_STRING, MODE_LIST, MODE_MAP: begin
        cls_nxt.data = {32'd0, in_req.size};
        if (in_req.size[31:4] == '0) begin
          cls_nxt.marker = mk_tiny | {4'd0, in_req.size[3:0]};
        end else if (in_req.size[31:8] == '0) begin
          cls_nxt.marker = mk_8;  cls_nxt.nbytes = 4'd1;
        end else if (in_req.size[31:16] == '0) begin
          cls_nxt.marker = mk_16; cls_nxt.nbytes = 4'd2;
        end else begin
          cls_nxt.marker = mk_32; cls_nxt.nbytes = 4'd4;
        end
      end
      MODE_STRUCT: begin
        cls_nxt.data   = {56'd0, in_req.struct_tag};
        cls_nxt.nbytes = 4'd1;
        if (in_req.size[31:4] != '0) begin
          cls_nxt.marker = MK_STRCT_SAT;
          cls_nxt.err    = 1'b1;
        end else begin
          cls_nxt.marker = MK_TINY_STRCT | {4'd0, in_req.size[3:0]};
        end
      end
      MODE_RAW: cls_nxt.marker = in_req.value[7:0];
      // Unknown kinds produce no bytes: drop here
      default: keep = 1'b0;
    endcase
  end

  assign advance      = !valid_r || cls_ready;
  assign in_req.ready = advance;

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_req.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls_data  = cls_r;

endmodule

`default_nettype wire

@@ rtl/core/pvenc_frame.sv @@
// ----------------------------------------------------------------------------
// pvenc_frame
// Stage two: lay out marker and payload bytes, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module pvenc_frame (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cls_valid,
  input  wire pvenc_pkg::cls_t   cls_data,
  output logic                   cls_ready,
  output logic                   frm_valid,
  output pvenc_pkg::frame_t      frm_data,
  input  wire logic              frm_ready
);
  import pvenc_pkg::*;

  logic        valid_r;
  frame_t      frm_r;
  frame_t      frm_nxt;
  logic [6:0]  shamt;
  logic [63:0] payload;
  logic        advance;

  // Left-align the payload so that its top byte sits behind the marker
  always_comb begin
    shamt   = {4'(4'd8 - cls_data.nbytes), 3'b000};
    payload = cls_data.data << shamt;
    frm_nxt.bytes[0] = cls_data.marker;
    for (int k = 1; k < MAX_BYTES; k++) begin
      frm_nxt.bytes[k] = payload[63 - 8 * (k - 1) -: 8];
    end
    frm_nxt.count = 4'(cls_data.nbytes + 4'd1);
    frm_nxt.err   = cls_data.err;
  end

  assign advance   = !valid_r || frm_ready;
  assign cls_ready = advance;

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frm_r <= frm_nxt;
    end
  end

  assign frm_valid = valid_r;
  assign frm_data  = frm_r;

endmodule

`default_nettype wire

@@ rtl/core/pvenc_serial.sv @@
// ----------------------------------------------------------------------------
// pvenc_serial
// Stage three: shift a frame out one byte per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packstream_value_encoder_macros.svh"

module pvenc_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              frm_valid,
  input  wire pvenc_pkg::frame_t frm_data,
  output logic                   frm_ready,
  pvenc_out_if.source            out_res
);
  import pvenc_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic [MAX_BYTES-1:0][7:0] buf_r;
  logic [MAX_BYTES-1:0][7:0] buf_nxt;
  logic [3:0]                cnt_r;
  logic [3:0]                cnt_nxt;
  logic                      err_r;
  logic                      err_nxt;
  logic                      last;
  logic                      take;
  logic                      load;

  assign last      = (cnt_r == 4'd1);
  assign take      = valid_r && out_res.ready;
  assign frm_ready = !valid_r || (take && last);
  assign load      = frm_valid && frm_ready;

  // Load a new frame, or drop the byte just sent and advance
  always_comb begin
    valid_nxt = valid_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    if (load) begin
      valid_nxt = 1'b1;
      buf_nxt   = frm_data.bytes;
      cnt_nxt   = frm_data.count;
      err_nxt   = frm_data.err;
    end else if (take) begin
      valid_nxt = !last;
      buf_nxt   = buf_r >> 8;
      cnt_nxt   = 4'(cnt_r - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    err_r <= err_nxt;
  end

  assign out_res.valid    = valid_r;
  assign out_res.out_byte = buf_r[0];
  assign out_res.last     = last;
  assign out_res.error    = err_r;

  // A held frame always has bytes left
  `PVENC_ASSERT_IMP(a_cnt_live, clk, rst_n, valid_r, (cnt_r != 4'd0) && (cnt_r <= 4'd9))
  // A byte taken that is not the last keeps the frame alive
  `PVENC_ASSERT_NXT(a_more_bytes, clk, rst_n, take && !last, valid_r)
  // Error frames are two-byte structure headers
  `PVENC_ASSERT_IMP(a_err_short, clk, rst_n, valid_r && err_r, cnt_r <= 4'd2)

endmodule

`default_nettype wire
